FILE: sv/smfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfd_pkg
// Shared types and constants for the sync marker frame deframer.
// ----------------------------------------------------------------------------
package smfd_pkg;

    // Record framing words
    localparam logic [31:0] SYNC_WORD = 32'h1ACF_FC1D;
    localparam logic [31:0] TAIL_WORD = 32'h1234_5678;

    // Defaults
    localparam int          NAME_BYTES_DEF  = 200;
    localparam int          LEN_W           = 24;
    localparam logic [23:0] MAX_LEN_RESET   = 24'd8388608;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_VERSION = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_STATUS  = 2'd3
    } kind_t;

    // Record status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HEAD  = 3'd1,
        ST_BAD_SUM   = 3'd2,
        ST_BAD_TAIL  = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_TOO_LONG  = 3'd5,
        ST_RSVD6     = 3'd6,
        ST_RSVD7     = 3'd7
    } status_t;

    // One result item, with a valid flag for the core-to-queue hop
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        status_t    status;
        logic       last;
    } result_t;

endpackage

FILE: sv/smfd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfd_core
// Record parser: one byte per fire, up to two results per byte.
// ----------------------------------------------------------------------------
module smfd_core
    import smfd_pkg::*;
#(
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       in_byte,
    input  logic             in_end,
    input  logic [LEN_W-1:0] max_len,
    output result_t          res0,
    output result_t          res1
);

    typedef enum logic [2:0] {
        PH_HEAD    = 3'd0,
        PH_LEN     = 3'd1,
        PH_NAME    = 3'd2,
        PH_VER     = 3'd3,
        PH_PAY     = 3'd4,
        PH_TAIL    = 3'd5,
        PH_SUM     = 3'd6,
        PH_UNUSED  = 3'd7
    } phase_t;

    localparam logic [LEN_W-1:0] NAME_LAST = LEN_W'(NAME_BYTES);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [31:0]      ws_reg, ws_next;
    logic [7:0]       sum_reg, sum_next;
    logic             halt_reg, halt_next;

    logic [7:0]       sum_add;
    logic [31:0]      ws_sh;
    logic [LEN_W-1:0] cnt_inc;
    logic             word_done;
    logic             closed;
    logic             clr;
    logic             too_long;

    // Helper values for this byte
    assign sum_add   = sum_reg + in_byte;
    assign ws_sh     = {ws_reg[23:0], in_byte};
    assign cnt_inc   = cnt_reg + 1'b1;
    assign word_done = (cnt_reg == LEN_W'(3));
    assign too_long  = (ws_sh[31:LEN_W] != '0) || (ws_sh[LEN_W-1:0] > max_len);

    // Next state and results
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        ws_next    = ws_reg;
        sum_next   = sum_reg;
        halt_next  = halt_reg;
        res0       = '0;
        res1       = '0;
        closed     = 1'b0;
        clr        = 1'b0;

        if (halt_reg)
        begin
            // dropping bytes until the buffer ends
            if (in_end)
            begin
                halt_next = 1'b0;
                clr       = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_HEAD:
                begin
                    sum_next = sum_add;
                    ws_next  = ws_sh;
                    cnt_next = cnt_inc;
                    if (word_done)
                    begin
                        if (ws_sh != SYNC_WORD)
                        begin
                            res0      = '{1'b1, KIND_STATUS, 8'h00, ST_BAD_HEAD, 1'b1};
                            closed    = 1'b1;
                            halt_next = 1'b1;
                            clr       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                            cnt_next   = '0;
                            ws_next    = '0;
                        end
                    end
                end
                PH_LEN:
                begin
                    sum_next = sum_add;
                    ws_next  = ws_sh;
                    cnt_next = cnt_inc;
                    if (word_done)
                    begin
                        if (too_long)
                        begin
                            res0      = '{1'b1, KIND_STATUS, 8'h00, ST_TOO_LONG, 1'b1};
                            closed    = 1'b1;
                            halt_next = 1'b1;
                            clr       = 1'b1;
                        end
                        else
                        begin
                            len_next   = ws_sh[LEN_W-1:0];
                            phase_next = PH_NAME;
                            cnt_next   = '0;
                            ws_next    = '0;
                        end
                    end
                end
                PH_NAME:
                begin
                    sum_next = sum_add;
                    res0     = '{1'b1, KIND_NAME, in_byte, ST_OK, 1'b0};
                    cnt_next = cnt_inc;
                    if (cnt_inc >= NAME_LAST)
                    begin
                        phase_next = PH_VER;
                        cnt_next   = '0;
                    end
                end
                PH_VER:
                begin
                    sum_next = sum_add;
                    cnt_next = cnt_inc;
                    if (word_done)
                    begin
                        res0       = '{1'b1, KIND_VERSION, in_byte, ST_OK, 1'b0};
                        phase_next = (len_reg != '0) ? PH_PAY : PH_TAIL;
                        cnt_next   = '0;
                        ws_next    = '0;
                    end
                end
                PH_PAY:
                begin
                    sum_next = sum_add;
                    res0     = '{1'b1, KIND_PAYLOAD, in_byte, ST_OK, 1'b0};
                    cnt_next = cnt_inc;
                    if (cnt_inc >= len_reg)
                    begin
                        phase_next = PH_TAIL;
                        cnt_next   = '0;
                        ws_next    = '0;
                    end
                end
                PH_TAIL:
                begin
                    sum_next = sum_add;
                    ws_next  = ws_sh;
                    cnt_next = cnt_inc;
                    if (word_done)
                    begin
                        phase_next = PH_SUM;
                        cnt_next   = '0;
                    end
                end
                PH_SUM:
                begin
                    // checksum error wins over tail error
                    res0 = '{1'b1, KIND_STATUS, 8'h00, ST_OK, 1'b1};
                    if (sum_reg != in_byte)
                    begin
                        res0.status = ST_BAD_SUM;
                        halt_next   = 1'b1;
                    end
                    else if (ws_reg != TAIL_WORD)
                    begin
                        res0.status = ST_BAD_TAIL;
                        halt_next   = 1'b1;
                    end
                    closed = 1'b1;
                    clr    = 1'b1;
                end
                default:
                begin
                    clr = 1'b1;
                end
            endcase

            // buffer end inside a record
            if (in_end)
            begin
                if (!closed)
                begin
                    if (res0.valid)
                        res1 = '{1'b1, KIND_STATUS, 8'h00, ST_TRUNCATED, 1'b1};
                    else
                        res0 = '{1'b1, KIND_STATUS, 8'h00, ST_TRUNCATED, 1'b1};
                end
                halt_next = 1'b0;
                clr       = 1'b1;
            end
        end

        if (clr)
        begin
            phase_next = PH_HEAD;
            cnt_next   = '0;
            len_next   = '0;
            ws_next    = '0;
            sum_next   = '0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            cnt_reg   <= '0;
            len_reg   <= '0;
            ws_reg    <= '0;
            sum_reg   <= '0;
            halt_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            ws_reg    <= ws_next;
            sum_reg   <= sum_next;
            halt_reg  <= halt_next;
        end
    end

    // A second result only ever follows a first one
    assert property (@(posedge clk) disable iff (!rst_n)
        res1.valid |-> res0.valid)
        else $error("second result without a first");

    // Status results always close a record
    assert property (@(posedge clk) disable iff (!rst_n)
        (res0.valid && res0.kind == KIND_STATUS) |-> res0.last)
        else $error("status result without record_last");

    // Entering the halt state always restarts the record
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halt_reg) |-> (phase_reg == PH_HEAD && cnt_reg == '0 && sum_reg == '0))
        else $error("halt set with record state not cleared");

endmodule

FILE: sv/smfd_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfd_out_queue
// Small shifting result queue: takes up to two results a cycle, gives one when the reader is ready.
// ----------------------------------------------------------------------------
module smfd_out_queue
    import smfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  result_t push0,
    input  result_t push1,
    output logic    room,
    output result_t head,
    output logic    head_valid,
    input  logic    pop_ready
);

    localparam int DEPTH = 4;
    localparam int CW    = $clog2(DEPTH + 1);

    result_t         ent_reg   [DEPTH];
    result_t         ent_next  [DEPTH];
    result_t         shifted   [DEPTH];
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   base;
    logic            pop;

    assign head_valid = (count_reg != '0);
    assign head       = ent_reg[0];
    assign pop        = head_valid && pop_ready;
    // Room for the two results one byte can cause
    assign room       = (count_reg <= CW'(DEPTH - 2));
    assign base       = count_reg - CW'(pop);

    // Shift down on pop, append new results behind the survivors
    always_comb
    begin
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            shifted[i] = pop ? ent_reg[i + 1] : ent_reg[i];
        end
        shifted[DEPTH - 1] = ent_reg[DEPTH - 1];

        for (int i = 0; i < DEPTH; i++)
        begin
            ent_next[i] = shifted[i];
            if (CW'(i) == base && push0.valid)
                ent_next[i] = push0;
            else if (CW'(i) == base + 1'b1 && push1.valid)
                ent_next[i] = push1;
        end

        count_next = base + CW'(push0.valid) + CW'(push1.valid);
    end

    // Entries hold payload only
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue overflow");

    // Nothing is pushed when the producer was told there is no room
    assert property (@(posedge clk) disable iff (!rst_n)
        !room |-> !push0.valid)
        else $error("push into a full result queue");

    // Fill count holds steady when nothing was pushed and nothing was popped
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(push0.valid) && !$past(pop) |-> $stable(count_reg))
        else $error("fill count changed with no push or pop");

endmodule

FILE: sv/sync_marker_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_marker_frame_deframer
// Splits a byte stream of sync-marked records into fields and a status.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one buffer byte per request in s_tdata[7:0], with
//   s_tlast on the final byte of the whole buffer.
//   Output stream m_*: name bytes, the last version byte and payload bytes,
//   then one status request per record with m_tlast set. m_tuser carries the
//   kind, m_tdata the byte and the status code.
//   cfg_we / cfg_wdata write the maximum payload length; write only while
//   the block is idle.
// Path: an accepted byte is held in the input register, then parsed
//   into the result queue, whose registered head is offered on m_*.
// Throughput: one byte per cycle while the queue has room. A byte can cause
//   two results (a forwarded byte and a truncated status at buffer end); the
//   four-entry queue takes both at once, drains one per cycle with m_tready high.
// Reset: parser returns to hunting for the sync word, queue empties and the
//   length limit returns to 8388608.
// Stall: when m_tready is low the queue fills; the parser stops once fewer
//   than two entries are free, and s_tready drops when the input register
//   is also held. No result is lost.
// ----------------------------------------------------------------------------
module sync_marker_frame_deframer
    import smfd_pkg::*;
#(
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // config
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,   // max_payload_len
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // [7:0] in_byte
    input  logic             s_tlast,     // buffer_end
    // output stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,     // [7:0] out_byte, [10:8] out_status, zero fill
    output logic [1:0]       m_tuser,     // [1:0] out_kind
    output logic             m_tlast      // record_last
);

    logic [LEN_W-1:0] max_len_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_end_reg;
    logic             fire;
    logic             room;
    result_t          res0, res1;
    result_t          head;

    // Parser consumes the held byte when the queue has room
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    // Length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    smfd_core #(
        .NAME_BYTES (NAME_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .in_end  (in_end_reg),
        .max_len (max_len_reg),
        .res0    (res0),
        .res1    (res1)
    );

    smfd_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (fire ? res0 : '0),
        .push1      (fire ? res1 : '0),
        .room       (room),
        .head       (head),
        .head_valid (m_tvalid),
        .pop_ready  (m_tready)
    );

    // Output packing
    assign m_tdata = {5'b0, head.status, head.data};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

FILE: tb/deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches both streams of the record deframer and predicts its output. Every
// accepted byte runs through a local record parser that produces the expected
// name, version, payload and status requests. Every accepted output request
// is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module deframer_checker
    import smfd_pkg::*;
#(
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,     // [7:0] in_byte
    input  logic             s_tlast,     // buffer_end
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [15:0]      m_tdata,     // [7:0] out_byte, [10:8] out_status, zero fill
    input  logic [1:0]       m_tuser,     // [1:0] out_kind
    input  logic             m_tlast,     // record_last
    output int               fail_count,
    output int               pending,
    output int               results_checked,
    output int               records_closed
);

    typedef enum logic [2:0] {
        HUNT_SYNC,
        GET_LEN,
        GET_NAME,
        GET_VERSION,
        GET_PAYLOAD,
        GET_TAIL,
        GET_SUM
    } rec_phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        status_t    status;
        logic       last;
    } deframe_result_t;

    deframe_result_t expected_q[$];
    deframe_result_t want;

    // Parser state
    rec_phase_t  phase;
    int unsigned field_cnt;
    logic [23:0] pay_len;
    logic [23:0] len_limit;
    logic [31:0] shift_word;
    logic [7:0]  rec_sum;
    logic        halted;
    logic        closed;
    status_t     close_status;

    task automatic clear_record();
        phase      = HUNT_SYNC;
        field_cnt  = 0;
        pay_len    = '0;
        shift_word = '0;
        rec_sum    = '0;
    endtask

    task automatic add_result(input kind_t kind, input logic [7:0] data,
                              input status_t status, input logic last);
        expected_q.push_back('{kind: kind, data: data, status: status, last: last});
        if (kind == KIND_STATUS)
            records_closed++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_limit       = MAX_LEN_RESET;
            halted          = 1'b0;
            fail_count      = 0;
            results_checked = 0;
            records_closed  = 0;
            clear_record();
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
                len_limit = cfg_wdata;

            // Predict the requests caused by an accepted byte
            if (s_tvalid && s_tready)
            begin
                if (halted)
                begin
                    // dropping until buffer end
                    if (s_tlast)
                    begin
                        halted = 1'b0;
                        clear_record();
                    end
                end
                else
                begin
                    closed = 1'b0;
                    case (phase)
                        HUNT_SYNC, GET_LEN:
                        begin
                            rec_sum    = rec_sum + s_tdata;
                            shift_word = {shift_word[23:0], s_tdata};
                            field_cnt++;
                            if (field_cnt == 4)
                            begin
                                if (phase == HUNT_SYNC && shift_word != SYNC_WORD)
                                begin
                                    add_result(KIND_STATUS, 8'h00, ST_BAD_HEAD, 1'b1);
                                    closed = 1'b1;
                                    halted = 1'b1;
                                    clear_record();
                                end
                                else if (phase == HUNT_SYNC)
                                begin
                                    phase      = GET_LEN;
                                    field_cnt  = 0;
                                    shift_word = '0;
                                end
                                else if (shift_word > {8'h00, len_limit})
                                begin
                                    add_result(KIND_STATUS, 8'h00, ST_TOO_LONG, 1'b1);
                                    closed = 1'b1;
                                    halted = 1'b1;
                                    clear_record();
                                end
                                else
                                begin
                                    pay_len    = shift_word[23:0];
                                    phase      = GET_NAME;
                                    field_cnt  = 0;
                                    shift_word = '0;
                                end
                            end
                        end
                        GET_NAME:
                        begin
                            rec_sum = rec_sum + s_tdata;
                            add_result(KIND_NAME, s_tdata, ST_OK, 1'b0);
                            field_cnt++;
                            if (field_cnt >= NAME_BYTES)
                            begin
                                phase     = GET_VERSION;
                                field_cnt = 0;
                            end
                        end
                        GET_VERSION:
                        begin
                            // only the last version byte is forwarded
                            rec_sum = rec_sum + s_tdata;
                            field_cnt++;
                            if (field_cnt == 4)
                            begin
                                add_result(KIND_VERSION, s_tdata, ST_OK, 1'b0);
                                phase      = (pay_len != 0) ? GET_PAYLOAD : GET_TAIL;
                                field_cnt  = 0;
                                shift_word = '0;
                            end
                        end
                        GET_PAYLOAD:
                        begin
                            rec_sum = rec_sum + s_tdata;
                            add_result(KIND_PAYLOAD, s_tdata, ST_OK, 1'b0);
                            field_cnt++;
                            if (field_cnt >= pay_len)
                            begin
                                phase      = GET_TAIL;
                                field_cnt  = 0;
                                shift_word = '0;
                            end
                        end
                        GET_TAIL:
                        begin
                            rec_sum    = rec_sum + s_tdata;
                            shift_word = {shift_word[23:0], s_tdata};
                            field_cnt++;
                            if (field_cnt == 4)
                            begin
                                phase     = GET_SUM;
                                field_cnt = 0;
                            end
                        end
                        GET_SUM:
                        begin
                            // checksum error wins over tail error
                            if (rec_sum != s_tdata)
                                close_status = ST_BAD_SUM;
                            else if (shift_word != TAIL_WORD)
                                close_status = ST_BAD_TAIL;
                            else
                                close_status = ST_OK;
                            add_result(KIND_STATUS, 8'h00, close_status, 1'b1);
                            closed = 1'b1;
                            if (close_status != ST_OK)
                                halted = 1'b1;
                            clear_record();
                        end
                        default:
                            clear_record();
                    endcase

                    // buffer end inside an open record
                    if (s_tlast)
                    begin
                        if (!closed)
                            add_result(KIND_STATUS, 8'h00, ST_TRUNCATED, 1'b1);
                        clear_record();
                        halted = 1'b0;
                    end
                end
            end

            // Compare an accepted output request with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected request kind %0d tdata %04h last %0b",
                                 $realtime, m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (m_tuser !== want.kind ||
                        m_tdata !== {5'd0, want.status, want.data} ||
                        m_tlast !== want.last)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: request %0d mismatch: expected kind %0d byte %02h",
                                      " status %0d last %0b, got kind %0d tdata %04h last %0b"},
                                     $realtime, results_checked, want.kind, want.data,
                                     want.status, want.last, m_tuser, m_tdata, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sync marker frame deframer. Sends short directed buffers,
// then random buffers of well-formed records with random names, versions and
// payloads, mixed with corrupted heads, lengths, tails and checksums, cut
// records and noise, under several length limits and flow-control modes.
// The checker beside the block predicts and compares every request.
// ----------------------------------------------------------------------------
module tb;
    import smfd_pkg::*;

    localparam int SEGMENTS  = 6;
    localparam int SEG_BYTES = 200;

    typedef enum int {
        FAULT_NONE,
        FAULT_HEAD,
        FAULT_LEN,
        FAULT_SUM,
        FAULT_TAIL,
        FAULT_CUT
    } fault_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic [7:0]       s_tdata   = '0;
    logic             s_tlast   = 1'b0;
    logic             m_tready  = 1'b0;
    logic             s_tready;
    logic             m_tvalid;
    logic [15:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;

    int fail_count;
    int pending;
    int results_checked;
    int records_closed;

    logic [7:0]  buf_q[$];          // bytes of the buffer under construction
    logic [23:0] cur_limit    = MAX_LEN_RESET;
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    int          quiet_left   = 0;
    int          bytes_sent   = 0;
    int          buffers_sent = 0;
    logic        gaps_on      = 1'b0;

    always #2 clk = ~clk;

    sync_marker_frame_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    deframer_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .records_closed  (records_closed)
    );

    // Receiver stalls, with rare stretches of full-rate draining
    always @(posedge clk)
    begin
        if (quiet_left != 0)
        begin
            quiet_left <= quiet_left - 1;
            m_tready   <= 1'b1;
        end
        else if ($urandom_range(999) == 0)
        begin
            quiet_left <= $urandom_range(60, 20);
            m_tready   <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_word(input logic [31:0] w);
        buf_q.push_back(w[31:24]);
        buf_q.push_back(w[23:16]);
        buf_q.push_back(w[15:8]);
        buf_q.push_back(w[7:0]);
    endtask

    // Append one record to the buffer, broken as the fault says
    task automatic add_record(input fault_t fault);
        int          first;
        int          n_pay;
        int          keep;
        int          total;
        int          i;
        int          cap;
        logic [31:0] head_word;
        logic [31:0] len_word;
        logic [31:0] tail_word;
        logic [7:0]  sum;
        first     = buf_q.size();
        head_word = SYNC_WORD;
        tail_word = TAIL_WORD;
        if (fault == FAULT_HEAD)
            head_word ^= 32'h1 << $urandom_range(31);
        if (fault == FAULT_TAIL || (fault == FAULT_SUM && $urandom_range(1) == 1))
            tail_word ^= 32'h1 << $urandom_range(31);

        // payload length: mostly short, sometimes the limit itself
        cap = (cur_limit > 40) ? 40 : int'(cur_limit);
        if (fault == FAULT_LEN)
        begin
            if (cur_limit != 24'hFF_FFFF && $urandom_range(1) == 1)
                len_word = {8'h00, cur_limit} + 32'd1;
            else
                len_word = $urandom() | 32'h0100_0000;
        end
        else if (fault == FAULT_CUT && cur_limit > 300 && $urandom_range(1) == 1)
            len_word = $urandom_range(int'(cur_limit));
        else if (cur_limit <= 300 && $urandom_range(5) == 0)
            len_word = {8'h00, cur_limit};
        else if ($urandom_range(15) == 0)
            len_word = $urandom_range((cur_limit > 300) ? 300 : int'(cur_limit));
        else
            len_word = $urandom_range(cap);
        // a huge accepted length is only used in a cut record
        n_pay = (len_word > 300) ? 40 : int'(len_word);

        push_word(head_word);
        push_word(len_word);
        for (i = 0; i < NAME_BYTES_DEF + 4 + n_pay; i++)
            buf_q.push_back(8'($urandom()));
        push_word(tail_word);
        sum = 8'h00;
        for (i = first; i < buf_q.size(); i++)
            sum += buf_q[i];
        if (fault == FAULT_SUM)
            sum += 8'($urandom_range(255, 1));
        buf_q.push_back(sum);

        // trim after a bad word, or cut the record short
        total = buf_q.size() - first;
        case (fault)
            FAULT_HEAD: keep = 4 + $urandom_range(6);
            FAULT_LEN:  keep = 8 + $urandom_range(6);
            FAULT_CUT:
                if ($urandom_range(1) == 1)
                    keep = total - $urandom_range(12, 1);
                else
                    keep = $urandom_range(total - 1, 1);
            default:    keep = total;
        endcase
        while (buf_q.size() > first + keep)
            void'(buf_q.pop_back());
    endtask

    // Send the buffer, tlast on its final byte
    task automatic send_buffer();
        int i;
        gaps_on = ($urandom_range(4) != 0);
        for (i = 0; i < buf_q.size(); i++)
        begin
            while (gaps_on && $urandom_range(99) < gap_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= buf_q[i];
            s_tlast  <= (i == buf_q.size() - 1);
            do
                @(posedge clk);
            while (s_tready !== 1'b1);
            bytes_sent++;
        end
        buf_q.delete();
        buffers_sent++;
    endtask

    // Hold off until every predicted request has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_limit(input logic [23:0] value);
        drain();
        // bytes that cause no request may still sit in the pipeline
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = value;
    endtask

    // Main stimulus
    initial
    begin
        int          seg;
        int          seg_start;
        int          pick;
        int          n;
        fault_t      fault;
        logic [23:0] limit;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_limit(24'd5);

        // lone bytes at buffer end, extreme values
        buf_q.push_back(8'h00);
        send_buffer();
        buf_q.push_back(8'hFF);
        send_buffer();
        // bad head, then dropped bytes up to buffer end
        push_word(SYNC_WORD ^ 32'h1);
        buf_q.push_back(8'h1A);
        buf_q.push_back(8'hCF);
        send_buffer();
        // length one past the limit, on the last byte of the buffer
        push_word(SYNC_WORD);
        push_word(32'd6);
        send_buffer();
        // one name byte, then buffer end: byte request and truncated status
        push_word(SYNC_WORD);
        push_word(32'd0);
        buf_q.push_back(8'hA5);
        send_buffer();

        // Random buffers under several limits and flow-control modes
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:       limit = 24'd0;
                1:       limit = 24'hFF_FFFF;
                2:       limit = 24'd1;
                3:       limit = 24'($urandom_range(300, 2));
                4:       limit = MAX_LEN_RESET;
                5:       limit = 24'($urandom());
                6:       limit = 24'hFF_FFFF;
                default: limit = 24'($urandom_range(40, 2));
            endcase
            write_limit(limit);
            case (seg % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 72; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 72; end
                default: begin gap_pct = 31; stall_pct = 31; end
            endcase

            seg_start = bytes_sent;
            while (bytes_sent - seg_start < SEG_BYTES)
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                begin
                    // noise, sometimes led by a valid sync word
                    if ($urandom_range(3) == 0)
                        push_word(SYNC_WORD);
                    n = $urandom_range(12, 1);
                    repeat (n) buf_q.push_back(8'($urandom()));
                end
                else if (pick < 30)
                    add_record(($urandom_range(1) == 1) ? FAULT_HEAD : FAULT_LEN);
                else
                begin
                    // now and then two records back to back in one buffer
                    if ($urandom_range(7) == 0)
                        add_record(FAULT_NONE);
                    pick = $urandom_range(99);
                    fault = (pick < 50) ? FAULT_NONE :
                            (pick < 65) ? FAULT_SUM  :
                            (pick < 80) ? FAULT_TAIL : FAULT_CUT;
                    add_record(fault);
                    if (fault == FAULT_SUM || fault == FAULT_TAIL)
                        repeat ($urandom_range(5)) buf_q.push_back(8'($urandom()));
                end
                send_buffer();
                if ($urandom_range(19) == 0)
                    drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes in %0d buffers under %0d length limits and 4 flow modes.",
                 bytes_sent, buffers_sent, SEGMENTS + 1);
        $display("Checked %0d requests, %0d record statuses, %0d mismatches.",
                 results_checked, records_closed, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
